// File: hw/rtl/pts_pkg.sv
// Shared types, codes and constants of the periodic trigger schedule.
`default_nettype none

package pts_pkg;

   // Default sizes
   localparam int MAX_TRIGGERS_DEF = 16;
   localparam int TIME_BITS_DEF    = 64;

   // Field widths
   localparam int OP_W        = 2;
   localparam int ID_W        = 4;
   localparam int OFFSET_W    = 32;
   localparam int PERIOD_W    = 32;
   localparam int STATUS_W    = 2;
   localparam int NEXT_TIME_W = 64;

   // Most results that one fire request may produce
   localparam int RESULTS_CAP = 16;
   localparam int GRP_CNT_W   = $clog2(RESULTS_CAP);

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 2'd0,
      OP_FIRE = 2'd1,
      OP_STEP = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_EMPTY      = 2'd2,
      ST_NONE_ACTIVE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_DISPATCH,
      FSM_ADD_HEAD,
      FSM_WALK,
      FSM_INSERT,
      FSM_LINK,
      FSM_FIRE_CUR,
      FSM_FIRE_NEXT,
      FSM_FIRE_LAST,
      FSM_STEP_LINK,
      FSM_STEP_OFF
   } fsm_type;

   // Memory access controls for the entry table
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctrl_type;

endpackage

`default_nettype wire

// File: hw/rtl/pts_entry_ram.sv
// Entry table of the trigger schedule: one write port, one registered read port.
`default_nettype none

module pts_entry_ram #(
   parameter int DEPTH  = pts_pkg::MAX_TRIGGERS_DEF,
   parameter int ADDR_W = 4,
   parameter int WIDTH  = 41
) (
   input  wire                       clock,
   input  pts_pkg::ram_ctrl_type     ctrl,
   input  wire  [ADDR_W-1:0]         wr_addr,
   input  wire  [WIDTH-1:0]          wr_data,
   input  wire  [ADDR_W-1:0]         rd_addr,
   output logic [WIDTH-1:0]          rd_data
);
   import pts_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/periodic_trigger_schedule_core.sv
// Top level of the periodic trigger schedule: control sequencer, state and result register.
`default_nettype none

// Keeps up to MAX_TRIGGERS trigger entries in one synchronous table, linked in
// ascending order of offset, with the head, the active entry, the fill count
// and the period start time held in registers. Requests are taken one at a
// time. An add writes the new entry at once on an empty table; else it reads
// the head and either makes the new entry the head or walks the list one
// entry per read, writes the new entry and links it behind its predecessor.
// A fire emits one result per group member (up to 16 results); a step reads
// the active entry's link, if any, and then the new active entry's offset.
// The table read is registered, and the list walk uses its single read port
// once per entry. The result register lets a finished result wait while the
// next request is taken. The period register is written through the csr
// port, which is always ready.

module periodic_trigger_schedule_core #(
   parameter int MAX_TRIGGERS = pts_pkg::MAX_TRIGGERS_DEF,
   parameter int TIME_BITS    = pts_pkg::TIME_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [pts_pkg::OP_W-1:0]            req_op,
   input  wire  [pts_pkg::ID_W-1:0]            req_trigger_id,
   input  wire  [pts_pkg::OFFSET_W-1:0]        req_offset,
   // result channel
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [pts_pkg::STATUS_W-1:0]        rsp_status,
   output logic [pts_pkg::ID_W-1:0]            rsp_fired_id,
   output logic [pts_pkg::NEXT_TIME_W-1:0]     rsp_next_time,
   output logic                                rsp_last,
   // configuration
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [pts_pkg::PERIOD_W-1:0]        csr_period
);
   import pts_pkg::*;

   localparam int SLOT_BITS = $clog2(MAX_TRIGGERS + 1);
   localparam int IDX_BITS  = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;
   localparam int ENTRY_W   = OFFSET_W + ID_W + SLOT_BITS;
   localparam logic [SLOT_BITS-1:0] NULL_SLOT = SLOT_BITS'(MAX_TRIGGERS);

   // ---------------------------------------------------------------- state
   fsm_type                 state_ff, state_in;
   logic [SLOT_BITS-1:0]    head_ff, head_in;
   logic [SLOT_BITS-1:0]    active_ff, active_in;
   logic [SLOT_BITS-1:0]    count_ff, count_in;
   logic [TIME_BITS-1:0]    pstart_ff, pstart_in;
   logic [PERIOD_W-1:0]     period_ff;
   logic [GRP_CNT_W-1:0]    grp_cnt_ff, grp_cnt_in;

   // latched request
   logic [OP_W-1:0]         op_ff;
   logic [ID_W-1:0]         id_ff;
   logic [OFFSET_W-1:0]     off_ff;

   // entry under the walk (insert predecessor or fire group member)
   logic [SLOT_BITS-1:0]    walk_slot_ff, walk_slot_in;
   logic [OFFSET_W-1:0]     walk_off_ff, walk_off_in;
   logic [ID_W-1:0]         walk_id_ff, walk_id_in;
   logic [SLOT_BITS-1:0]    walk_link_ff, walk_link_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [ID_W-1:0]         rsp_id_ff;
   logic [TIME_BITS-1:0]    rsp_time_ff;
   logic                    rsp_last_ff;

   // table port
   ram_ctrl_type            ram_ctrl;
   logic [IDX_BITS-1:0]     wr_addr, rd_addr;
   logic [ENTRY_W-1:0]      wr_data, rd_data;
   logic [OFFSET_W-1:0]     rd_off;
   logic [ID_W-1:0]         rd_id;
   logic [SLOT_BITS-1:0]    rd_link;

   // result launch
   logic                    emit;
   logic                    out_free;
   logic                    rsp_load;
   status_type              emit_status;
   logic [ID_W-1:0]         emit_id;
   logic [TIME_BITS-1:0]    emit_time;
   logic                    emit_last;

   logic                    req_accept;
   logic                    head_ok, active_ok, rd_link_ok, full;
   logic                    grp_more;

   assign rd_link = rd_data[SLOT_BITS-1:0];
   assign rd_id   = rd_data[SLOT_BITS +: ID_W];
   assign rd_off  = rd_data[SLOT_BITS+ID_W +: OFFSET_W];

   assign head_ok    = (head_ff < NULL_SLOT);
   assign active_ok  = (active_ff < NULL_SLOT);
   assign rd_link_ok = (rd_link < NULL_SLOT);
   assign full       = (count_ff == NULL_SLOT);

   assign req_stall  = (state_ff != FSM_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = emit && out_free;
   assign csr_ready  = 1'b1;

   assign grp_more = (rd_off == walk_off_ff) && (grp_cnt_ff != GRP_CNT_W'(RESULTS_CAP - 1));

   // ------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      active_in    = active_ff;
      count_in     = count_ff;
      pstart_in    = pstart_ff;
      grp_cnt_in   = grp_cnt_ff;
      walk_slot_in = walk_slot_ff;
      walk_off_in  = walk_off_ff;
      walk_id_in   = walk_id_ff;
      walk_link_in = walk_link_ff;
      ram_ctrl     = '0;
      wr_addr      = count_ff[IDX_BITS-1:0];
      wr_data      = {off_ff, id_ff, NULL_SLOT};
      rd_addr      = head_ff[IDX_BITS-1:0];
      emit         = 1'b0;
      emit_status  = ST_OK;
      emit_id      = '0;
      emit_time    = '0;
      emit_last    = 1'b1;

      case (state_ff)
         FSM_IDLE: begin
            if (req_accept) begin
               state_in = FSM_DISPATCH;
            end
         end

         FSM_DISPATCH: begin
            case (op_ff)
               OP_ADD: begin
                  if (full) begin
                     emit        = 1'b1;
                     emit_status = ST_FULL;
                     if (out_free) begin
                        state_in = FSM_IDLE;
                     end
                  end else if (!head_ok) begin
                     emit = 1'b1;
                     if (out_free) begin
                        ram_ctrl.wr_en = 1'b1;
                        head_in        = count_ff;
                        count_in       = count_ff + 1'b1;
                        state_in       = FSM_IDLE;
                     end
                  end else begin
                     ram_ctrl.rd_en = 1'b1;
                     state_in       = FSM_ADD_HEAD;
                  end
               end
               OP_FIRE: begin
                  if (!active_ok) begin
                     emit        = 1'b1;
                     emit_status = ST_NONE_ACTIVE;
                     if (out_free) begin
                        state_in = FSM_IDLE;
                     end
                  end else begin
                     ram_ctrl.rd_en = 1'b1;
                     rd_addr        = active_ff[IDX_BITS-1:0];
                     grp_cnt_in     = '0;
                     state_in       = FSM_FIRE_CUR;
                  end
               end
               OP_STEP: begin
                  if (!head_ok) begin
                     emit        = 1'b1;
                     emit_status = ST_EMPTY;
                     emit_time   = {TIME_BITS{1'b1}};
                     if (out_free) begin
                        state_in = FSM_IDLE;
                     end
                  end else if (active_ok) begin
                     ram_ctrl.rd_en = 1'b1;
                     rd_addr        = active_ff[IDX_BITS-1:0];
                     state_in       = FSM_STEP_LINK;
                  end else begin
                     // first step: wrap to the head and open a new period
                     ram_ctrl.rd_en = 1'b1;
                     active_in      = head_ff;
                     pstart_in      = pstart_ff + TIME_BITS'(period_ff);
                     state_in       = FSM_STEP_OFF;
                  end
               end
               default: begin
                  emit = 1'b1;
                  if (out_free) begin
                     state_in = FSM_IDLE;
                  end
               end
            endcase
         end

         FSM_ADD_HEAD: begin
            if (off_ff < rd_off) begin
               emit    = 1'b1;
               wr_data = {off_ff, id_ff, head_ff};
               if (out_free) begin
                  ram_ctrl.wr_en = 1'b1;
                  head_in        = count_ff;
                  count_in       = count_ff + 1'b1;
                  state_in       = FSM_IDLE;
               end
            end else begin
               walk_slot_in = head_ff;
               walk_off_in  = rd_off;
               walk_id_in   = rd_id;
               walk_link_in = rd_link;
               if (rd_link_ok) begin
                  ram_ctrl.rd_en = 1'b1;
                  rd_addr        = rd_link[IDX_BITS-1:0];
                  state_in       = FSM_WALK;
               end else begin
                  state_in = FSM_INSERT;
               end
            end
         end

         FSM_WALK: begin
            // read data is the successor of the current predecessor
            if (rd_off < off_ff) begin
               walk_slot_in = walk_link_ff;
               walk_off_in  = rd_off;
               walk_id_in   = rd_id;
               walk_link_in = rd_link;
               if (rd_link_ok) begin
                  ram_ctrl.rd_en = 1'b1;
                  rd_addr        = rd_link[IDX_BITS-1:0];
               end else begin
                  state_in = FSM_INSERT;
               end
            end else begin
               state_in = FSM_INSERT;
            end
         end

         FSM_INSERT: begin
            ram_ctrl.wr_en = 1'b1;
            wr_data        = {off_ff, id_ff, walk_link_ff};
            state_in       = FSM_LINK;
         end

         FSM_LINK: begin
            emit    = 1'b1;
            wr_addr = walk_slot_ff[IDX_BITS-1:0];
            wr_data = {walk_off_ff, walk_id_ff, count_ff};
            if (out_free) begin
               ram_ctrl.wr_en = 1'b1;
               count_in       = count_ff + 1'b1;
               state_in       = FSM_IDLE;
            end
         end

         FSM_FIRE_CUR: begin
            walk_slot_in = active_ff;
            walk_off_in  = rd_off;
            walk_id_in   = rd_id;
            walk_link_in = rd_link;
            if (rd_link_ok) begin
               ram_ctrl.rd_en = 1'b1;
               rd_addr        = rd_link[IDX_BITS-1:0];
               state_in       = FSM_FIRE_NEXT;
            end else begin
               state_in = FSM_FIRE_LAST;
            end
         end

         FSM_FIRE_NEXT: begin
            emit      = 1'b1;
            emit_id   = walk_id_ff;
            emit_last = !grp_more;
            if (out_free) begin
               if (grp_more) begin
                  active_in    = walk_link_ff;
                  walk_slot_in = walk_link_ff;
                  walk_id_in   = rd_id;
                  walk_link_in = rd_link;
                  grp_cnt_in   = grp_cnt_ff + 1'b1;
                  if (rd_link_ok) begin
                     ram_ctrl.rd_en = 1'b1;
                     rd_addr        = rd_link[IDX_BITS-1:0];
                  end else begin
                     state_in = FSM_FIRE_LAST;
                  end
               end else begin
                  state_in = FSM_IDLE;
               end
            end
         end

         FSM_FIRE_LAST: begin
            emit    = 1'b1;
            emit_id = walk_id_ff;
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end

         FSM_STEP_LINK: begin
            ram_ctrl.rd_en = 1'b1;
            state_in       = FSM_STEP_OFF;
            if (rd_link_ok) begin
               active_in = rd_link;
               rd_addr   = rd_link[IDX_BITS-1:0];
            end else begin
               // end of list: wrap to the head
               active_in = head_ff;
               pstart_in = pstart_ff + TIME_BITS'(period_ff);
            end
         end

         FSM_STEP_OFF: begin
            emit      = 1'b1;
            emit_time = pstart_ff + TIME_BITS'(rd_off);
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // --------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         head_ff      <= NULL_SLOT;
         active_ff    <= NULL_SLOT;
         count_ff     <= '0;
         pstart_ff    <= '0;
         period_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         pstart_ff    <= pstart_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            period_ff <= csr_period;
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_cnt_ff   <= grp_cnt_in;
      walk_slot_ff <= walk_slot_in;
      walk_off_ff  <= walk_off_in;
      walk_id_ff   <= walk_id_in;
      walk_link_ff <= walk_link_in;
      if (req_accept) begin
         op_ff  <= req_op;
         id_ff  <= req_trigger_id;
         off_ff <= req_offset;
      end
      if (rsp_load) begin
         rsp_status_ff <= emit_status;
         rsp_id_ff     <= emit_id;
         rsp_time_ff   <= emit_time;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_fired_id  = rsp_id_ff;
   assign rsp_next_time = NEXT_TIME_W'(rsp_time_ff);
   assign rsp_last      = rsp_last_ff;

   // ------------------------------------------------------- entry table
   pts_entry_ram #(
      .DEPTH  (MAX_TRIGGERS),
      .ADDR_W (IDX_BITS),
      .WIDTH  (ENTRY_W)
   ) u_entry_ram (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // -------------------------------------------------------- assertions
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NULL_SLOT)
      else $error("fill count beyond table depth");

   a_head_tracks_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (head_ff == NULL_SLOT))
      else $error("head and fill count disagree");

   a_active_needs_head: assert property (@(posedge clock) disable iff (reset)
      active_ok |-> head_ok)
      else $error("active entry on an empty table");

   a_no_overwrite_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("held result overwritten");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_ctrl.wr_en |-> (count_ff < NULL_SLOT))
      else $error("table write on a full table");

endmodule

`default_nettype wire

// File: tb/sv/periodic_trigger_schedule_checker.sv
// Checker for the periodic trigger schedule: watches all channels, predicts and compares results.
`timescale 1ns / 1ps

module periodic_trigger_schedule_checker (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   input  wire                             req_stall,
   input  wire  [pts_pkg::OP_W-1:0]        req_op,
   input  wire  [pts_pkg::ID_W-1:0]        req_trigger_id,
   input  wire  [pts_pkg::OFFSET_W-1:0]    req_offset,
   input  wire                             rsp_valid,
   input  wire                             rsp_stall,
   input  wire  [pts_pkg::STATUS_W-1:0]    rsp_status,
   input  wire  [pts_pkg::ID_W-1:0]        rsp_fired_id,
   input  wire  [pts_pkg::NEXT_TIME_W-1:0] rsp_next_time,
   input  wire                             rsp_last,
   input  wire                             csr_valid,
   input  wire                             csr_ready,
   input  wire  [pts_pkg::PERIOD_W-1:0]    csr_period,
   output int                              outstanding,
   output int                              mismatch_count,
   output int                              checked_count
);
   import pts_pkg::*;

   localparam int SLOTS = MAX_TRIGGERS_DEF;
   localparam logic [4:0] NO_SLOT = 5'(SLOTS);

   typedef struct {
      status_type             status;
      logic [ID_W-1:0]        fired_id;
      logic [NEXT_TIME_W-1:0] next_time;
      logic                   last;
   } sched_result;

   logic [OFFSET_W-1:0] slot_offset [SLOTS];
   logic [ID_W-1:0]     slot_id [SLOTS];
   logic [4:0]          slot_link [SLOTS];
   logic [4:0]          head_slot;
   logic [4:0]          active_slot;
   logic [4:0]          fill;
   logic [63:0]         period_base;
   logic [PERIOD_W-1:0] period_len;
   sched_result         results_due [$];
   int                  faults = 0;
   int                  matched = 0;

   function automatic void queue_result(status_type st, logic [ID_W-1:0] id,
                                        logic [NEXT_TIME_W-1:0] t, logic lst);
      sched_result r;
      r.status    = st;
      r.fired_id  = id;
      r.next_time = t;
      r.last      = lst;
      results_due.push_back(r);
   endfunction

   function automatic void insert_trigger(logic [ID_W-1:0] id, logic [OFFSET_W-1:0] off);
      logic [4:0] prev;
      logic [4:0] s;
      int guard;
      if (fill >= NO_SLOT) begin
         queue_result(ST_FULL, '0, '0, 1'b1);
      end else begin
         s = fill;
         fill = fill + 5'd1;
         slot_offset[s] = off;
         slot_id[s] = id;
         if (head_slot == NO_SLOT) begin
            slot_link[s] = NO_SLOT;
            head_slot = s;
         end else if (off < slot_offset[head_slot]) begin
            slot_link[s] = head_slot;
            head_slot = s;
         end else begin
            // advance while the successor's offset is still below the new one
            prev = head_slot;
            guard = 0;
            while (slot_link[prev] != NO_SLOT && slot_offset[slot_link[prev]] < off
                   && guard < SLOTS) begin
               prev = slot_link[prev];
               guard++;
            end
            slot_link[s] = slot_link[prev];
            slot_link[prev] = s;
         end
         queue_result(ST_OK, '0, '0, 1'b1);
      end
   endfunction

   function automatic void fire_group();
      logic [4:0] nx;
      logic more;
      int n;
      if (active_slot == NO_SLOT) begin
         queue_result(ST_NONE_ACTIVE, '0, '0, 1'b1);
      end else begin
         n = 0;
         do begin
            nx = slot_link[active_slot];
            more = (nx != NO_SLOT) && (slot_offset[nx] == slot_offset[active_slot])
                   && (n + 1 < RESULTS_CAP);
            queue_result(ST_OK, slot_id[active_slot], '0, !more);
            n++;
            if (more) begin
               active_slot = nx;
            end
         end while (more);
      end
   endfunction

   function automatic void step_schedule();
      if (head_slot == NO_SLOT) begin
         queue_result(ST_EMPTY, '0, '1, 1'b1);
      end else begin
         if (active_slot != NO_SLOT) begin
            active_slot = slot_link[active_slot];
         end
         // wrap to the head and open a new period
         if (active_slot == NO_SLOT) begin
            active_slot = head_slot;
            period_base = period_base + 64'(period_len);
         end
         queue_result(ST_OK, '0, period_base + 64'(slot_offset[active_slot]), 1'b1);
      end
   endfunction

   always @(posedge clock) begin
      sched_result want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_offset[i] = '0;
            slot_id[i] = '0;
            slot_link[i] = '0;
         end
         head_slot = NO_SLOT;
         active_slot = NO_SLOT;
         fill = '0;
         period_base = '0;
         period_len = '0;
         results_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result: status %0d id %0d time %h last %b", $time,
                        rsp_status, rsp_fired_id, rsp_next_time, rsp_last);
               faults++;
            end else begin
               want = results_due.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
                  faults++;
               end
               if (rsp_fired_id !== want.fired_id) begin
                  $display("%0t: fired_id expected %0d got %0d", $time, want.fired_id,
                           rsp_fired_id);
                  faults++;
               end
               if (rsp_next_time !== want.next_time) begin
                  $display("%0t: next_time expected %h got %h", $time, want.next_time,
                           rsp_next_time);
                  faults++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %b got %b", $time, want.last, rsp_last);
                  faults++;
               end
               matched++;
            end
         end
         if (csr_valid && csr_ready) begin
            period_len = csr_period;
         end
         if (req_valid && !req_stall) begin
            case (req_op)
               OP_ADD:  insert_trigger(req_trigger_id, req_offset);
               OP_FIRE: fire_group();
               OP_STEP: step_schedule();
               default: queue_result(ST_OK, '0, '0, 1'b1);
            endcase
         end
      end
      outstanding <= results_due.size();
      mismatch_count <= faults;
      checked_count <= matched;
   end

endmodule

// File: tb/sv/periodic_trigger_schedule_core_tb.sv
// Testbench top for the periodic trigger schedule: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module periodic_trigger_schedule_core_tb;
   import pts_pkg::*;

   localparam logic [OP_W-1:0] OP_RSVD = 2'd3;
   localparam int PHASES = 4;
   localparam int PHASE_REQUESTS = 100;
   localparam int HOLD_CYCLES = 300;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   wire                     req_stall;
   logic [OP_W-1:0]         req_op = OP_ADD;
   logic [ID_W-1:0]         req_trigger_id = '0;
   logic [OFFSET_W-1:0]     req_offset = '0;
   wire                     rsp_valid;
   logic                    rsp_stall = 1'b0;
   wire  [STATUS_W-1:0]     rsp_status;
   wire  [ID_W-1:0]         rsp_fired_id;
   wire  [NEXT_TIME_W-1:0]  rsp_next_time;
   wire                     rsp_last;
   logic                    csr_valid = 1'b0;
   wire                     csr_ready;
   logic [PERIOD_W-1:0]     csr_period = '0;

   int   outstanding;
   int   mismatch_count;
   int   checked_count;
   int   requests_sent = 0;
   int   periods_written = 0;
   logic quiet = 1'b0;
   logic hold_go = 1'b0;
   logic hold_done = 1'b0;
   int   hold_left = 0;

   logic [PERIOD_W-1:0] period_plan [PHASES] = '{32'hFFFF_FFFF, 32'd1, 32'h0, 32'h0};

   periodic_trigger_schedule_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_trigger_id (req_trigger_id),
      .req_offset     (req_offset),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_fired_id   (rsp_fired_id),
      .rsp_next_time  (rsp_next_time),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_period     (csr_period)
   );

   periodic_trigger_schedule_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_trigger_id (req_trigger_id),
      .req_offset     (req_offset),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_fired_id   (rsp_fired_id),
      .rsp_next_time  (rsp_next_time),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_period     (csr_period),
      .outstanding    (outstanding),
      .mismatch_count (mismatch_count),
      .checked_count  (checked_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // Result side: random stall, one long hold-off once asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 7);
      end
   end

   task automatic send_req(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [OFFSET_W-1:0] off);
      while (!quiet && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_trigger_id <= id;
      req_offset <= off;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   task automatic send_random();
      int pick;
      logic [OFFSET_W-1:0] off;
      pick = $urandom_range(0, 99);
      // mostly coarse offsets so that equal-offset groups form
      off = ($urandom_range(0, 2) == 0) ? $urandom : 32'd1000 * $urandom_range(0, 4);
      if (pick < 15) begin
         send_req(OP_ADD, ID_W'($urandom_range(0, 15)), off);
      end else if (pick < 50) begin
         send_req(OP_FIRE, ID_W'($urandom_range(0, 15)), $urandom);
      end else if (pick < 95) begin
         send_req(OP_STEP, ID_W'($urandom_range(0, 15)), $urandom);
      end else begin
         send_req(OP_RSVD, ID_W'($urandom_range(0, 15)), $urandom);
      end
   endtask

   task automatic write_period(input logic [PERIOD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_period <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      periods_written++;
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (24) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_period(32'h0);

      send_req(OP_STEP, 4'h0, 32'h0);            // empty table
      send_req(OP_FIRE, 4'h0, 32'h0);            // nothing active
      send_req(OP_RSVD, 4'h0, 32'h0);
      send_req(OP_ADD, 4'h0, 32'd1000);          // first entry
      send_req(OP_FIRE, 4'h0, 32'h0);            // still nothing active
      send_req(OP_ADD, 4'hF, 32'hFFFF_FFFF);     // new tail
      send_req(OP_ADD, 4'h1, 32'h0);             // new head
      send_req(OP_ADD, 4'h2, 32'd1000);          // equal to an inner entry
      send_req(OP_ADD, 4'h3, 32'd1000);
      send_req(OP_ADD, 4'h4, 32'h0);             // equal to the head
      send_req(OP_ADD, 4'h5, 32'd500);
      send_req(OP_STEP, 4'h0, 32'h0);            // first step wraps to the head
      send_req(OP_FIRE, 4'h0, 32'h0);
      send_req(OP_STEP, 4'h0, 32'h0);
      send_req(OP_FIRE, 4'h0, 32'h0);
      send_req(OP_STEP, 4'h0, 32'h0);
      send_req(OP_FIRE, 4'h0, 32'h0);            // group of equal offsets
      send_req(OP_STEP, 4'h0, 32'h0);
      send_req(OP_FIRE, 4'h0, 32'h0);
      send_req(OP_STEP, 4'h0, 32'h0);            // end of list wraps
      send_req(OP_RSVD, 4'hF, 32'hFFFF_FFFF);
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         write_period(phase == 2 ? $urandom : period_plan[phase]);
         quiet <= (phase == 1);
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            if (phase == 2 && i == 30) begin
               hold_go <= 1'b1;
            end
            send_random();
         end
         settle();
      end

      $display("Run covered %0d requests and %0d checked results over %0d period settings,",
               requests_sent, checked_count, periods_written);
      $display("with empty, idle, full and reserved requests and a long result hold-off.");
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
